### rtl/core/m32h_pkg.sv
`default_nettype none

package m32h_pkg;

  localparam int unsigned WordW = 32;

  localparam logic CFG_SEED_LO = 1'b0;
  localparam logic CFG_SEED_HI = 1'b1;

  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last_item;
    logic             extra;
  } op_t;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } chain_t;

  function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] x, input int unsigned n);
    logic [2*WordW-1:0] d;
    d = {x, x} << n;
    return d[2*WordW-1:WordW];
  endfunction

  function automatic chain_t mix_round(input chain_t c);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    chain_t r;
    a = c.a;
    b = c.b;
    b = b ^ a;
    a = rol(a, 20);
    a = a + b;
    b = rol(b, 9);
    b = b ^ a;
    a = rol(a, 27);
    a = a + b;
    b = rol(b, 19);
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic logic [WordW-1:0] pad_tail(input logic [WordW-1:0] w,
                                                input logic [1:0] cnt);
    logic [WordW-1:0] t;
    case (cnt)
      2'd0:    t = {24'h0, PadByte};
      2'd1:    t = {16'h0, PadByte, w[7:0]};
      2'd2:    t = {8'h0, PadByte, w[15:0]};
      2'd3:    t = {PadByte, w[23:0]};
      default: t = {24'h0, PadByte};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/core/marvin32_seeded_hash_core.sv
// Sequencing: a non-last item is absorbed as it leaves the two-entry queue; a last item
//   passes the absorb, pad (only when it carries four bytes) and mix rounds before the hash
//   sits in the output register; the mix round waits until the output register is free.
// Throughput: non-last items at one per cycle, set by the round unit, paused by last items.
// Reset: asynchronous, active low; clears queue, chain, message state and seeds.
`default_nettype none

module marvin32_seeded_hash_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,  // data_word [31:0], byte_count [34:32], zero fill
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata   // hash_first_word [31:0], hash_second_word [63:32]
);

  m32h_pkg::chain_t seed_q;
  m32h_pkg::chain_t hash;
  m32h_pkg::op_t    op;
  logic             op_valid;
  logic             op_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        m32h_pkg::CFG_SEED_LO: seed_q.a <= cfg_data_i;
        m32h_pkg::CFG_SEED_HI: seed_q.b <= cfg_data_i;
        default:               seed_q   <= seed_q;
      endcase
    end
  end

  m32h_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .word_i     (s_axis_tdata[31:0]),
    .count_i    (s_axis_tdata[34:32]),
    .last_i     (s_axis_tlast),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  m32h_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .op_valid_i   (op_valid),
    .op_i         (op),
    .op_pop_o     (op_pop),
    .hash_valid_o (m_axis_tvalid),
    .hash_o       (hash),
    .hash_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {hash.b, hash.a};

endmodule

`default_nettype wire

### rtl/core/m32h_front.sv
`default_nettype none

module m32h_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [m32h_pkg::WordW-1:0]   word_i,
  input  wire logic [2:0]                   count_i,
  input  wire logic                         last_i,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  output logic                              op_valid_o,
  output m32h_pkg::op_t                     op_o,
  input  wire logic                         op_pop_i
);

  m32h_pkg::op_t op_cls;
  m32h_pkg::op_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  logic          full_word;

  always_comb begin
    full_word = count_i[2];
    op_cls.last_item = last_i;
    op_cls.extra     = last_i && full_word;
    if (!last_i || full_word) begin
      op_cls.word = word_i;
    end else begin
      op_cls.word = m32h_pkg::pad_tail(word_i, count_i[1:0]);
    end
  end

  assign ready_o    = (cnt_q != 2'd2);
  assign push       = valid_i && ready_o;
  assign pop        = op_pop_i && (cnt_q != 2'd0);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= op_cls;
    end
  end

endmodule

`default_nettype wire

### rtl/core/m32h_back.sv
`default_nettype none

module m32h_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire m32h_pkg::chain_t             seed_i,
  input  wire logic                         op_valid_i,
  input  wire m32h_pkg::op_t                op_i,
  output logic                              op_pop_o,
  output logic                              hash_valid_o,
  output m32h_pkg::chain_t                  hash_o,
  input  wire logic                         hash_ready_i
);

  typedef enum logic [1:0] {
    PH_ABSORB,
    PH_PAD,
    PH_MIX
  } phase_e;

  phase_e           phase_q, phase_d;
  m32h_pkg::chain_t chain_q, chain_d;
  m32h_pkg::chain_t hash_q;
  m32h_pkg::chain_t mix_in;
  m32h_pkg::chain_t mix_out;
  logic             in_msg_q, in_msg_d;
  logic             hash_valid_q, hash_valid_d;
  logic             out_free;
  logic             step;
  logic [m32h_pkg::WordW-1:0] addend;

  assign out_free = !hash_valid_q || hash_ready_i;
  assign step     = op_valid_i && ((phase_q != PH_MIX) || out_free);

  always_comb begin
    case (phase_q)
      PH_ABSORB: addend = op_i.word;
      PH_PAD:    addend = {24'h0, m32h_pkg::PadByte};
      PH_MIX:    addend = '0;
      default:   addend = '0;
    endcase
    mix_in   = in_msg_q ? chain_q : seed_i;
    mix_in.a = mix_in.a + addend;
    mix_out  = m32h_pkg::mix_round(mix_in);
  end

  always_comb begin
    phase_d      = phase_q;
    chain_d      = chain_q;
    in_msg_d     = in_msg_q;
    hash_valid_d = hash_valid_q && !hash_ready_i;
    op_pop_o     = 1'b0;
    if (step) begin
      chain_d  = mix_out;
      in_msg_d = 1'b1;
      case (phase_q)
        PH_ABSORB: begin
          if (!op_i.last_item) begin
            op_pop_o = 1'b1;
          end else if (op_i.extra) begin
            phase_d = PH_PAD;
          end else begin
            phase_d = PH_MIX;
          end
        end
        PH_PAD: begin
          phase_d = PH_MIX;
        end
        PH_MIX: begin
          op_pop_o     = 1'b1;
          phase_d      = PH_ABSORB;
          in_msg_d     = 1'b0;
          hash_valid_d = 1'b1;
        end
        default: begin
          phase_d = PH_ABSORB;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_ABSORB;
      chain_q      <= '0;
      in_msg_q     <= 1'b0;
      hash_valid_q <= 1'b0;
      hash_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      chain_q      <= chain_d;
      in_msg_q     <= in_msg_d;
      hash_valid_q <= hash_valid_d;
      if (step && (phase_q == PH_MIX)) begin
        hash_q <= mix_out;
      end
    end
  end

  assign hash_valid_o = hash_valid_q;
  assign hash_o       = hash_q;

endmodule

`default_nettype wire
